### src/hex_text_frame_parser_defines.svh
// Assertion macros shared by the frame parser RTL.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef HEX_TEXT_FRAME_PARSER_DEFINES_SVH
`define HEX_TEXT_FRAME_PARSER_DEFINES_SVH

// Plain clocked property, disabled during reset.
`define HTFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define HTFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/htfp_pkg.sv
// Types, constants and the hex digit decoder for the frame parser.
// No dependencies; imported by htfp_parse_step and hex_text_frame_parser.
`timescale 1ns / 1ps
`default_nettype none

package htfp_pkg;

    localparam logic [4:0] HDR_CHARS = 5'd20;
    localparam logic [7:0] CHAR_LF   = 8'h0A;

    // header field codes
    typedef enum logic [2:0] {
        FLD_LENGTH  = 3'd0,
        FLD_COUNTER = 3'd1,
        FLD_CTRL    = 3'd2,
        FLD_TYPE    = 3'd3,
        FLD_SENDER  = 3'd4,
        FLD_RECV    = 3'd5
    } field_t;

    // first character position of the address fields
    localparam logic [4:0] SENDER_START = 5'd8;
    localparam logic [4:0] RECV_START   = 5'd14;

    // configuration register indexes
    localparam logic REG_SKIP_FIRST = 1'b0;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_last;
    } in_t;

    typedef struct packed {
        logic [7:0]  frame_length;
        logic [7:0]  msg_counter;
        logic [7:0]  ctrl_byte;
        logic [7:0]  msg_type;
        logic [23:0] sender;
        logic [23:0] receiver;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        end_of_frame;
    } out_t;

    typedef struct packed {
        logic [7:0]  frame_length;
        logic [7:0]  msg_counter;
        logic [7:0]  ctrl_byte;
        logic [7:0]  msg_type;
        logic [23:0] sender;
        logic [23:0] receiver;
    } header_t;

    typedef struct packed {
        logic [4:0] pos;
        logic       held_valid;
        logic       nibble_phase;
        logic [3:0] pair_accum;
        logic       pair_bad;
        header_t    hdr;
    } state_t;

    // {digit ok, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/htfp_parse_step.sv
// Next-state and result logic for one character of a frame line.
// Depends on htfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htfp_parse_step
    import htfp_pkg::*;
(
    input  wire state_t st,
    input  wire logic   skip_first,
    input  wire in_t    item,
    output state_t      st_next,
    output logic        emit,
    output out_t        res
);

    logic       drop;
    logic [4:0] dec;
    logic       ok;
    logic [3:0] nib;
    logic [4:0] start;
    field_t     fld;
    logic       pbad;
    logic       have;
    logic [7:0] byte_val;
    state_t     work;

    assign dec = hex_decode(item.char_in);
    assign ok  = dec[4];
    assign nib = dec[3:0];
    assign drop = !st.held_valid && skip_first;

    always_comb
    begin
        if (st.pos < SENDER_START) begin
            start = {st.pos[4:1], 1'b0};
            fld   = field_t'({1'b0, st.pos[2:1]});
        end else if (st.pos < RECV_START) begin
            start = SENDER_START;
            fld   = FLD_SENDER;
        end else begin
            start = RECV_START;
            fld   = FLD_RECV;
        end
    end

    always_comb
    begin
        work = st;
        work.held_valid = 1'b1;
        have = 1'b0;
        byte_val = 8'd0;
        pbad = 1'b0;
        if (!drop) begin
            if (st.pos < HDR_CHARS) begin
                pbad = (st.pos == start) ? 1'b0 : st.pair_bad;
                if (!pbad) begin
                    if (!ok) begin
                        pbad = 1'b1;
                    end else begin
                        case (fld)
                            FLD_LENGTH:  work.hdr.frame_length = {st.hdr.frame_length[3:0], nib};
                            FLD_COUNTER: work.hdr.msg_counter  = {st.hdr.msg_counter[3:0], nib};
                            FLD_CTRL:    work.hdr.ctrl_byte    = {st.hdr.ctrl_byte[3:0], nib};
                            FLD_TYPE:    work.hdr.msg_type     = {st.hdr.msg_type[3:0], nib};
                            FLD_SENDER:  work.hdr.sender       = {st.hdr.sender[19:0], nib};
                            FLD_RECV:    work.hdr.receiver     = {st.hdr.receiver[19:0], nib};
                            default:     work.hdr.receiver     = st.hdr.receiver;
                        endcase
                    end
                end
                work.pair_bad = pbad;
                work.pos = st.pos + 5'd1;
            end else if (item.is_last && item.char_in == CHAR_LF) begin
                // trailing CR LF: drop any waiting first digit
                work.nibble_phase = 1'b0;
            end else if (!st.nibble_phase) begin
                work.pair_accum   = ok ? nib : 4'd0;
                work.pair_bad     = !ok;
                work.nibble_phase = 1'b1;
                if (item.is_last) begin
                    have     = 1'b1;
                    byte_val = {4'd0, work.pair_accum};
                end
            end else begin
                if (st.pair_bad) begin
                    byte_val = 8'd0;
                end else if (!ok) begin
                    byte_val = {4'd0, st.pair_accum};
                end else begin
                    byte_val = {st.pair_accum, nib};
                end
                have = 1'b1;
                work.nibble_phase = 1'b0;
            end
        end
    end

    assign emit = have || item.is_last;

    always_comb
    begin
        res.frame_length  = work.hdr.frame_length;
        res.msg_counter   = work.hdr.msg_counter;
        res.ctrl_byte     = work.hdr.ctrl_byte;
        res.msg_type      = work.hdr.msg_type;
        res.sender        = work.hdr.sender;
        res.receiver      = work.hdr.receiver;
        res.payload_byte  = byte_val;
        res.payload_valid = have;
        res.end_of_frame  = item.is_last;
    end

    // last character closes the line and clears all parse state
    assign st_next = item.is_last ? '0 : work;

endmodule

`default_nettype wire

### src/hex_text_frame_parser.sv
// Top level of the hex text frame parser: state, result register, APB port.
// Depends on htfp_pkg, htfp_parse_step and hex_text_frame_parser_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

// Hex text frame parser. Takes one ASCII character per transaction on the
// input channel and parses a line of hex digits: length, counter, control
// and type bytes (two digits each), sender and destination addresses (six
// digits each), then payload bytes, one per digit pair. A result is
// delivered for every completed payload byte and for the last character of
// the line (end_of_frame set); each result carries the header as parsed so
// far. A trailing CR LF is dropped, an unpaired final digit yields its nibble.
// Throughput is one character per cycle: all parsing of a character is
// combinational between the parse state registers and a single result
// register, and a new character is taken whenever that result register is
// empty or being drained in the same cycle. A result is registered and
// valid in the cycle after its character is accepted. Register skip_first
// (address 0x0, bit 0, reset 1) drops the first character of every line;
// write it only while the block is idle.

`include "hex_text_frame_parser_defines.svh"

module hex_text_frame_parser
    import htfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // character input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_t         in_data,
    // result output
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_t             out_data,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    state_t st_reg;
    state_t st_next;
    logic   skip_first_reg;
    logic   out_valid_reg;
    out_t   out_data_reg;
    logic   emit;
    out_t   res;
    logic   in_fire;
    logic   cfg_write;

    // ---------------------------------------------------------------
    // Configuration: single register at word 0
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_SKIP_FIRST) ? {31'd0, skip_first_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            skip_first_reg <= 1'b1;
        end else if (cfg_write && paddr[2] == REG_SKIP_FIRST) begin
            skip_first_reg <= pwdata[0];
        end
    end

    // ---------------------------------------------------------------
    // Parse step: combinational update of line state per character
    // ---------------------------------------------------------------
    htfp_parse_step u_step (
        .st         (st_reg),
        .skip_first (skip_first_reg),
        .item       (in_data),
        .st_next    (st_next),
        .emit       (emit),
        .res        (res)
    );

    // Input is taken whenever the result register can take a new value
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= '0;
        end else if (in_fire) begin
            st_reg <= st_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= emit;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire && emit) begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `HTFP_ASSERT_NEXT(a_emit_loads, in_fire && emit, out_valid_reg,
        "result of accepted character not presented")
    `HTFP_ASSERT_NEXT(a_line_clears, in_fire && in_data.is_last,
        st_reg.pos == 5'd0 && !st_reg.held_valid && !st_reg.nibble_phase,
        "line state not cleared after last character")
    `HTFP_ASSERT(a_pos_sat, st_reg.pos <= HDR_CHARS, "character position past header end")
    `HTFP_ASSERT(a_result_kind, !out_valid_reg || out_data_reg.payload_valid
        || out_data_reg.end_of_frame, "result with neither payload nor end of frame")

endmodule

`default_nettype wire

### dv/tb.sv
// Testbench for hex_text_frame_parser: a self-checking run of directed and random frame lines.
// Depends on htfp_pkg and the hex_text_frame_parser RTL; reads no files.
`timescale 1ns / 1ps

module tb;
    import htfp_pkg::*;

    // Run control
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_LIMIT = 5000;
    localparam int          RANDOM_PHASE_CHARS = 120;

    // skip_first sits at byte address 4 * index
    localparam logic [2:0] SKIP_FIRST_ADDR = {REG_SKIP_FIRST, 2'b00};

    // Characters that are not hex digits; several sit right next to a digit range.
    localparam logic [7:0] ODD_CHARS [12] = '{8'h0D, CHAR_LF, "g", "G", "/", ":", "@", 8'h60,
                                              8'h20, 8'h00, 8'hFF, 8'h7F};

    // How a well-formed line ends after its payload pairs
    typedef enum int {
        TAIL_PLAIN,   // last char completes a pair
        TAIL_CRLF,    // CR then LF; CR becomes a waiting digit that is thrown away
        TAIL_ODD,     // a lone final digit yields its nibble
        TAIL_LF       // LF right after a complete pair
    } tail_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_t         in_data;
    logic        out_valid;
    logic        out_ready;
    out_t        out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hex_text_frame_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // ------------------------------------------------------------------
    // Line parser shadow. Mirrors the block's per-line state; updated on
    // every accepted input transaction, cleared after the last char.
    // ------------------------------------------------------------------
    logic        skip_marker   = 1'b1;   // skip_first as last written (reset 1)
    logic [4:0]  line_pos      = '0;     // parsed chars, stops at HDR_CHARS
    logic        line_open     = 1'b0;   // first char of the line already seen
    logic        digit_pending = 1'b0;   // first payload digit waits for its partner
    logic [3:0]  pending_nibble = '0;
    logic        digit_bad     = 1'b0;   // header: field broken; payload: first digit not hex
    header_t     hdr_acc       = '0;

    out_t        parsed_queue[$];        // results still owed by the block

    int unsigned errors      = 0;
    int unsigned cycle_count = 0;
    int          chars_sent  = 0;

    // Stimulus knobs shared by sender and receiver
    logic        steady_flow = 1'b0;     // no gaps, no new random stalls while set (a hold-off still wins)
    int          hold_cycles = 0;        // long receiver hold-off, counted by the receiver
    int          stall_left  = 0;

    logic [7:0]  line_chars[$];          // the line about to be sent

    // Hex digit value, or -1 for anything else
    function automatic int nibble_of(logic [7:0] c);
        int v;
        v = -1;
        if (c inside {["0":"9"]}) v = int'(c) - int'("0");
        else if (c inside {["A":"F"]}) v = int'(c) - int'("A") + 10;
        else if (c inside {["a":"f"]}) v = int'(c) - int'("a") + 10;
        return v;
    endfunction

    function automatic void clear_line_state();
        line_pos       = '0;
        line_open      = 1'b0;
        digit_pending  = 1'b0;
        pending_nibble = '0;
        digit_bad      = 1'b0;
        hdr_acc        = '0;
    endfunction

    // One header char. Each field restarts its "broken" flag at its first
    // char; a non-hex char freezes the field for the rest of its chars.
    function automatic void header_digit(logic [4:0] p, int v);
        field_t     fld;
        logic [4:0] first;
        if (p < SENDER_START) begin
            fld   = field_t'({1'b0, p[2:1]});
            first = {p[4:1], 1'b0};
        end else if (p < RECV_START) begin
            fld   = FLD_SENDER;
            first = SENDER_START;
        end else begin
            fld   = FLD_RECV;
            first = RECV_START;
        end
        if (p == first) digit_bad = 1'b0;
        if (!digit_bad) begin
            if (v < 0) begin
                digit_bad = 1'b1;
            end else begin
                case (fld)
                    FLD_LENGTH:  hdr_acc.frame_length = {hdr_acc.frame_length[3:0], v[3:0]};
                    FLD_COUNTER: hdr_acc.msg_counter  = {hdr_acc.msg_counter[3:0], v[3:0]};
                    FLD_CTRL:    hdr_acc.ctrl_byte    = {hdr_acc.ctrl_byte[3:0], v[3:0]};
                    FLD_TYPE:    hdr_acc.msg_type     = {hdr_acc.msg_type[3:0], v[3:0]};
                    FLD_SENDER:  hdr_acc.sender       = {hdr_acc.sender[19:0], v[3:0]};
                    default:     hdr_acc.receiver     = {hdr_acc.receiver[19:0], v[3:0]};
                endcase
            end
        end
    endfunction

    // Advance the shadow by one accepted char; queue the result it owes.
    function automatic void parse_char(in_t t);
        int         v;
        logic       dropped;
        logic       have;
        logic [7:0] pay;
        out_t       r;
        v       = nibble_of(t.char_in);
        dropped = 1'b0;
        have    = 1'b0;
        pay     = '0;
        if (!line_open) begin
            line_open = 1'b1;
            dropped   = skip_marker;
        end
        if (!dropped) begin
            if (line_pos < HDR_CHARS) begin
                header_digit(line_pos, v);
                line_pos++;
            end else if (t.is_last && t.char_in == CHAR_LF) begin
                // trailing LF: any waiting first digit is dropped too
                digit_pending = 1'b0;
            end else if (!digit_pending) begin
                pending_nibble = (v < 0) ? 4'h0 : v[3:0];
                digit_bad      = (v < 0);
                digit_pending  = 1'b1;
                if (t.is_last) begin
                    have = 1'b1;
                    pay  = {4'h0, pending_nibble};
                end
            end else begin
                if (digit_bad) pay = 8'h00;
                else if (v < 0) pay = {4'h0, pending_nibble};
                else pay = {pending_nibble, v[3:0]};
                have          = 1'b1;
                digit_pending = 1'b0;
            end
        end
        if (have || t.is_last) begin
            r.frame_length  = hdr_acc.frame_length;
            r.msg_counter   = hdr_acc.msg_counter;
            r.ctrl_byte     = hdr_acc.ctrl_byte;
            r.msg_type      = hdr_acc.msg_type;
            r.sender        = hdr_acc.sender;
            r.receiver      = hdr_acc.receiver;
            r.payload_byte  = pay;
            r.payload_valid = have;
            r.end_of_frame  = t.is_last;
            parsed_queue = {parsed_queue, r};
        end
        if (t.is_last) clear_line_state();
    endfunction

    task automatic compare_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks results first, then predicts from the input
    // transaction of the same edge (each result is registered first, so never shows on its own edge).
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        out_t want;
        if (rst_n && out_valid && out_ready) begin
            if (parsed_queue.size() == 0) begin
                $error("result with nothing expected: %p", out_data);
                errors++;
            end else begin
                want = parsed_queue.pop_front();
                compare_field("frame_length",  want.frame_length,  out_data.frame_length);
                compare_field("msg_counter",   want.msg_counter,   out_data.msg_counter);
                compare_field("ctrl_byte",     want.ctrl_byte,     out_data.ctrl_byte);
                compare_field("msg_type",      want.msg_type,      out_data.msg_type);
                compare_field("sender",        want.sender,        out_data.sender);
                compare_field("receiver",      want.receiver,      out_data.receiver);
                compare_field("payload_byte",  want.payload_byte,  out_data.payload_byte);
                compare_field("payload_valid", want.payload_valid, out_data.payload_valid);
                compare_field("end_of_frame",  want.end_of_frame,  out_data.end_of_frame);
            end
        end
        if (rst_n && in_valid && in_ready) parse_char(in_data);
    end

    // ------------------------------------------------------------------
    // Receiver: random ready with occasional stalls; a requested hold-off
    // takes priority and is counted down here.
    // ------------------------------------------------------------------
    initial begin
        int r;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (steady_flow) begin
                out_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) stall_left = $urandom_range(8, 40);
                out_ready <= (r >= 28);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // One input transaction; valid stays up until accepted.
    task automatic send_char(logic [7:0] c, logic last);
        int   gap;
        in_t  t;
        gap       = pick_gap();
        t.char_in = c;
        t.is_last = last;
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_chars.size(); i++) begin
            send_char(line_chars[i], i == line_chars.size() - 1);
        end
    endtask

    // Idle point: input quiet, every owed result delivered, pipeline empty.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (parsed_queue.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write of skip_first, then read back in the same selection.
    task automatic write_skip_first(logic val);
        drain_results();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SKIP_FIRST_ADDR;
        pwdata  <= {31'($urandom_range(0, 32'h7FFF_FFFF)), val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        skip_marker = val;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[0] !== val) begin
            $error("skip_first readback: expected %0h, got %0h", val, prdata[0]);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Line builders
    // ------------------------------------------------------------------
    function automatic logic [7:0] hex_char(int v);
        if (v < 10) return 8'("0" + v);
        if ($urandom_range(0, 1)) return 8'("A" + v - 10);
        return 8'("a" + v - 10);
    endfunction

    // Mostly hex digits; noise_pct percent odd chars or any byte.
    function automatic logic [7:0] pick_char(int noise_pct);
        if ($urandom_range(0, 99) >= noise_pct) return hex_char($urandom_range(0, 15));
        if ($urandom_range(0, 2) != 0) return ODD_CHARS[$urandom_range(0, 11)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void fill_wellformed(int n_pay, tail_t tail, int noise_pct);
        line_chars.delete();
        if (skip_marker) line_chars = {line_chars, 8'($urandom_range(0, 255))};
        repeat (HDR_CHARS) line_chars = {line_chars, pick_char(noise_pct)};
        repeat (2 * n_pay) line_chars = {line_chars, pick_char(noise_pct)};
        case (tail)
            TAIL_CRLF: begin
                line_chars = {line_chars, 8'h0D};
                line_chars = {line_chars, CHAR_LF};
            end
            TAIL_ODD:  line_chars = {line_chars, pick_char(noise_pct)};
            TAIL_LF:   line_chars = {line_chars, CHAR_LF};
            default: begin
                // plain end needs at least one pair to finish on
                if (n_pay == 0) repeat (2) line_chars = {line_chars, pick_char(noise_pct)};
            end
        endcase
    endfunction

    // Lines that end in or just past the header, sometimes on a LF.
    function automatic void fill_short();
        line_chars.delete();
        repeat ($urandom_range(1, 21)) line_chars = {line_chars, pick_char(30)};
        if ($urandom_range(0, 3) == 0) line_chars[line_chars.size() - 1] = CHAR_LF;
    endfunction

    function automatic void fill_noise();
        line_chars.delete();
        repeat ($urandom_range(1, 30)) line_chars = {line_chars, 8'($urandom_range(0, 255))};
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // skip_first is 1 out of reset: a lone marker gives an empty header,
    // and a marker plus one digit gives a partly filled length field.
    task automatic test_reset_marker();
        line_chars = '{"#"};
        send_line();
        line_chars = '{8'hFF, "5"};
        send_line();
    endtask

    // Header fields cut short by non-hex chars, bad first and bad second
    // payload digits, and a CR LF end that throws away the CR.
    task automatic test_header_and_pairs();
        write_skip_first(1'b0);
        line_chars = '{"f", "F", "A", "0", "9", 8'hFF, "x", "5",
                       "f", "E", "d", "C", "b", "A",
                       "0", "1", "Z", "9", "9", "9",
                       8'h00, "f", "7", "q", 8'h0D, CHAR_LF};
        send_line();
    endtask

    // All-ones header, then a lone final digit that yields its nibble.
    task automatic test_unpaired_tail();
        line_chars.delete();
        repeat (HDR_CHARS) line_chars = {line_chars, 8'h46};
        line_chars = {line_chars, 8'h62};
        send_line();
    endtask

    // Phases alternate skip_first; one phase runs with no idling at all.
    task automatic test_random_lines();
        int stop_at;
        int kind;
        for (int phase = 0; phase < 6; phase++) begin
            write_skip_first(phase % 2 == 0);
            steady_flow = (phase == 3);
            stop_at     = chars_sent + RANDOM_PHASE_CHARS;
            while (chars_sent < stop_at) begin
                kind = $urandom_range(0, 99);
                if (kind < 75) begin
                    fill_wellformed(($urandom_range(0, 99) < 85) ? $urandom_range(0, 6)
                                                                 : $urandom_range(7, 20),
                                    tail_t'($urandom_range(0, 3)),
                                    (kind < 55) ? 0 : 6);
                end else if (kind < 90) begin
                    fill_short();
                end else begin
                    fill_noise();
                end
                send_line();
            end
        end
        steady_flow = 1'b0;
    endtask

    // Receiver holds off for a long stretch while a long line keeps
    // coming, so the result register fills and in_ready drops.
    task automatic test_output_stall();
        drain_results();
        hold_cycles = 250;
        steady_flow = 1'b1;
        fill_wellformed(30, TAIL_CRLF, 0);
        send_line();
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned waited;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_marker();
        test_header_and_pairs();
        test_unpaired_tail();
        test_random_lines();
        test_output_stall();

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (parsed_queue.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (parsed_queue.size() != 0) begin
            $error("%0d results never arrived", parsed_queue.size());
            errors++;
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
